// File: rtl/crpt_pkg.sv
// crpt_pkg: shared types and constants for the cardinal spline point and tangent block
// no dependencies; used by crpt_ctrl, crpt_dp and catmull_rom_point_and_tangent
package crpt_pkg;

  localparam int FRAC    = 16;
  localparam int COORD_W = 32;
  localparam int UQ_W    = 17;
  localparam int DIR_W   = 16;
  localparam int WGT_W   = 22;
  localparam int EXT_W   = 40;
  localparam int ACC_W   = 58;
  localparam int CNT_W   = 6;

  localparam logic [UQ_W-1:0] ONE_FX     = 17'h10000;
  localparam logic [UQ_W-1:0] TENS_RESET = 17'h08000;

  localparam logic [CNT_W-1:0] PRE_LAST  = 6'd9;
  localparam logic [CNT_W-1:0] MAC_LAST  = 6'd24;
  localparam logic [CNT_W-1:0] SQ_LAST   = 6'd3;
  localparam logic [CNT_W-1:0] SQRT_LAST = 6'd32;
  localparam logic [CNT_W-1:0] DIV_LAST  = 6'd17;

  typedef enum logic [3:0] {
    DP_IDLE, DP_PUSH, DP_LOAD, DP_MUL, DP_CAPT, DP_WEIGHT, DP_MAC, DP_MAG,
    DP_NORM, DP_SQ, DP_SQRT_INIT, DP_SQRT, DP_DIV_INIT, DP_DIV, DP_DIV_DONE, DP_OUT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_WGT, S_MAC, S_MAG, S_CHK, S_NORM, S_SQ, S_SQRT, S_DIV, S_FIN
  } state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [4:0] idx;
    logic       acc_en;
    logic [4:0] acc_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic zero;
    logic in_range;
  } dp_sts_t;

endpackage

// File: rtl/crpt_ctrl.sv
// crpt_ctrl: sequencer for push and evaluate, drives datapath commands and the handshakes
// depends on crpt_pkg
module crpt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              operation_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  crpt_pkg::dp_sts_t sts_i,
  output crpt_pkg::dp_cmd_t cmd_o
);

  crpt_pkg::state_e             state_q, state_d;
  logic [crpt_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [1:0]                   axis_q, axis_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_set;
  logic [4:0]                   cnt_lo;

  assign cnt_lo = cnt_q[4:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crpt_pkg::S_IDLE;
      cnt_q       <= '0;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    axis_d        = axis_q;
    out_set       = 1'b0;
    cmd_o         = '0;
    cmd_o.op      = crpt_pkg::DP_IDLE;
    unique case (state_q)
      crpt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (operation_i) begin
            cmd_o.op = crpt_pkg::DP_LOAD;
            state_d  = crpt_pkg::S_PRE;
            cnt_d    = '0;
          end else begin
            cmd_o.op = crpt_pkg::DP_PUSH;
          end
        end
      end
      crpt_pkg::S_PRE: begin
        // even steps multiply, odd steps capture the product
        cmd_o.op  = cnt_q[0] ? crpt_pkg::DP_CAPT : crpt_pkg::DP_MUL;
        cmd_o.idx = cnt_q[5:1];
        if (cnt_q == crpt_pkg::PRE_LAST) begin
          state_d = crpt_pkg::S_WGT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      crpt_pkg::S_WGT: begin
        cmd_o.op = crpt_pkg::DP_WEIGHT;
        state_d  = crpt_pkg::S_MAC;
        cnt_d    = '0;
      end
      crpt_pkg::S_MAC: begin
        // product of step k is accumulated at step k+1
        cmd_o.op      = crpt_pkg::DP_MAC;
        cmd_o.idx     = cnt_lo;
        cmd_o.acc_en  = (cnt_q != '0);
        cmd_o.acc_idx = cnt_lo - 5'd1;
        if (cnt_q == crpt_pkg::MAC_LAST) begin
          state_d = crpt_pkg::S_MAG;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      crpt_pkg::S_MAG: begin
        cmd_o.op = crpt_pkg::DP_MAG;
        state_d  = crpt_pkg::S_CHK;
      end
      crpt_pkg::S_CHK: begin
        state_d = sts_i.zero ? crpt_pkg::S_FIN : crpt_pkg::S_NORM;
      end
      crpt_pkg::S_NORM: begin
        cmd_o.op = crpt_pkg::DP_NORM;
        if (sts_i.in_range) begin
          state_d = crpt_pkg::S_SQ;
          cnt_d   = '0;
        end
      end
      crpt_pkg::S_SQ: begin
        cmd_o.op      = crpt_pkg::DP_SQ;
        cmd_o.idx     = cnt_lo;
        cmd_o.acc_en  = (cnt_q != '0);
        cmd_o.acc_idx = cnt_lo - 5'd1;
        if (cnt_q == crpt_pkg::SQ_LAST) begin
          state_d = crpt_pkg::S_SQRT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      crpt_pkg::S_SQRT: begin
        cmd_o.op = (cnt_q == '0) ? crpt_pkg::DP_SQRT_INIT : crpt_pkg::DP_SQRT;
        if (cnt_q == crpt_pkg::SQRT_LAST) begin
          state_d = crpt_pkg::S_DIV;
          cnt_d   = '0;
          axis_d  = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      crpt_pkg::S_DIV: begin
        cmd_o.idx = {3'b000, axis_q};
        if (cnt_q == '0) begin
          cmd_o.op = crpt_pkg::DP_DIV_INIT;
        end else if (cnt_q == crpt_pkg::DIV_LAST) begin
          cmd_o.op = crpt_pkg::DP_DIV_DONE;
        end else begin
          cmd_o.op = crpt_pkg::DP_DIV;
        end
        if (cnt_q == crpt_pkg::DIV_LAST) begin
          cnt_d = '0;
          if (axis_q == 2'd2) begin
            state_d = crpt_pkg::S_FIN;
          end else begin
            axis_d = axis_q + 1'b1;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      crpt_pkg::S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op = crpt_pkg::DP_OUT;
          out_set  = 1'b1;
          state_d  = crpt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = crpt_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_set | (out_valid_q & out_stall_i);
  assign out_valid_o = out_valid_q;
  assign in_stall_o  = (state_q != crpt_pkg::S_IDLE);

  a_no_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != crpt_pkg::S_IDLE) |-> (cmd_o.op != crpt_pkg::DP_PUSH))
    else $error("push issued while evaluating");

endmodule

// File: rtl/crpt_dp.sv
// crpt_dp: window, weights, shared multiplier, accumulators, normalizer, square root, divider
// depends on crpt_pkg; sequenced by crpt_ctrl
module crpt_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  crpt_pkg::dp_cmd_t                 cmd_i,
  output crpt_pkg::dp_sts_t                 sts_o,
  input  logic                              tension_we_i,
  input  logic        [crpt_pkg::UQ_W-1:0]    tension_i,
  input  logic signed [crpt_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [crpt_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [crpt_pkg::COORD_W-1:0] point_z_i,
  input  logic        [crpt_pkg::UQ_W-1:0]    param_u_i,
  output logic signed [crpt_pkg::COORD_W-1:0] pos_x_o,
  output logic signed [crpt_pkg::COORD_W-1:0] pos_y_o,
  output logic signed [crpt_pkg::COORD_W-1:0] pos_z_o,
  output logic signed [crpt_pkg::DIR_W-1:0]   dir_x_o,
  output logic signed [crpt_pkg::DIR_W-1:0]   dir_y_o,
  output logic signed [crpt_pkg::DIR_W-1:0]   dir_z_o,
  output logic                              dir_degenerate_o
);

  localparam int EW = crpt_pkg::EXT_W;
  localparam int AW = crpt_pkg::ACC_W;
  localparam int WW = crpt_pkg::WGT_W;

  logic        [crpt_pkg::UQ_W-1:0]    tension_q;
  logic signed [crpt_pkg::COORD_W-1:0] win_q [3][4];
  logic        [crpt_pkg::UQ_W-1:0]    u_q, s_q, u2_q, u3_q;
  logic        [32:0]                  su_q, su2_q, su3_q;
  logic signed [WW-1:0]                bw_q [4];
  logic signed [WW-1:0]                dw_q [4];
  logic signed [31:0]                  mul_a, mul_b;
  logic signed [63:0]                  p_q;
  logic signed [AW-1:0]                acc_q [6];
  logic        [AW-1:0]                mag_q [3];
  logic        [2:0]                   neg_q;
  logic        [AW-1:0]                m_q;
  logic                                deg_q;
  logic        [63:0]                  sum_q, rem_q, res_q, bit_q;
  logic        [30:0]                  n_q;
  logic        [32:0]                  r_q;
  logic        [15:0]                  nlow_q, q_q;
  logic signed [crpt_pkg::DIR_W-1:0]   dir_q [3];

  logic signed [EW-1:0] e_su, e_su2, e_su3, e_ou, e_ou2, e_ou3, e_so, e_oo;
  logic signed [EW-1:0] bw_ex [4];
  logic signed [EW-1:0] dw_ex [4];
  logic signed [63:0]   p_rnd;
  logic        [AW-1:0] mag_new [3];
  logic        [AW-1:0] max_new;
  logic        [63:0]   sq_trial;
  logic        [44:0]   div_num;
  logic        [32:0]   div_t;
  logic        [2:0]    acc_sel;
  logic        [1:0]    mac_axis, mac_i;
  logic signed [WW-1:0] mac_w;

  function automatic logic signed [WW-1:0] rnd_w(input logic signed [EW-1:0] x);
    logic signed [EW-1:0] t;
    t = x + EW'(32768);
    return t[WW+15:16];
  endfunction

  function automatic logic signed [31:0] pos_sat(input logic signed [AW-1:0] x);
    logic signed [AW-1:0]    t;
    logic signed [AW-17:0]   sh;
    t  = x + AW'(32768);
    sh = t[AW-1:16];
    if (sh > (AW-16)'(32'sh7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else if (sh < -(AW-16)'(64'sh8000_0000)) begin
      return 32'sh8000_0000;
    end
    return sh[31:0];
  endfunction

  // cardinal basis weights at scale 2^32
  always_comb begin
    e_su  = $signed({7'b0, su_q});
    e_su2 = $signed({7'b0, su2_q});
    e_su3 = $signed({7'b0, su3_q});
    e_ou  = $signed({7'b0, u_q, 16'b0});
    e_ou2 = $signed({7'b0, u2_q, 16'b0});
    e_ou3 = $signed({7'b0, u3_q, 16'b0});
    e_so  = $signed({7'b0, s_q, 16'b0});
    e_oo  = $signed(40'h01_0000_0000);
    bw_ex[0] = -e_su3 + (e_su2 <<< 1) - e_su;
    bw_ex[1] = (e_ou3 <<< 1) - e_su3 + e_su2 - 40'sd3 * e_ou2 + e_oo;
    bw_ex[2] = e_su3 - (e_ou3 <<< 1) + 40'sd3 * e_ou2 - (e_su2 <<< 1) + e_su;
    bw_ex[3] = e_su3 - e_su2;
    dw_ex[0] = -(40'sd3 * e_su2) + (e_su <<< 2) - e_so;
    dw_ex[1] = 40'sd6 * e_ou2 - 40'sd3 * e_su2 + (e_su <<< 1) - 40'sd6 * e_ou;
    dw_ex[2] = 40'sd3 * e_su2 - 40'sd6 * e_ou2 + 40'sd6 * e_ou - (e_su <<< 2) + e_so;
    dw_ex[3] = 40'sd3 * e_su2 - (e_su <<< 1);
  end

  assign mac_axis = cmd_i.idx[4:3];
  assign mac_i    = cmd_i.idx[1:0];
  assign mac_w    = cmd_i.idx[2] ? dw_q[mac_i] : bw_q[mac_i];
  assign acc_sel  = {cmd_i.acc_idx[4:3], cmd_i.acc_idx[2]};

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      crpt_pkg::DP_MUL: begin
        unique case (cmd_i.idx[2:0])
          3'd0:    begin mul_a = {15'b0, u_q};  mul_b = {15'b0, u_q}; end
          3'd1:    begin mul_a = {15'b0, u2_q}; mul_b = {15'b0, u_q}; end
          3'd2:    begin mul_a = {15'b0, s_q};  mul_b = {15'b0, u_q}; end
          3'd3:    begin mul_a = {15'b0, s_q};  mul_b = {15'b0, u2_q}; end
          default: begin mul_a = {15'b0, s_q};  mul_b = {15'b0, u3_q}; end
        endcase
      end
      crpt_pkg::DP_MAC: begin
        mul_a = {{(32-WW){mac_w[WW-1]}}, mac_w};
        mul_b = win_q[mac_axis][mac_i];
      end
      crpt_pkg::DP_SQ: begin
        mul_a = {2'b0, mag_q[cmd_i.idx[1:0]][29:0]};
        mul_b = {2'b0, mag_q[cmd_i.idx[1:0]][29:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign p_rnd = p_q + 64'sd32768;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_new[k] = acc_q[2*k+1][AW-1] ? AW'(-acc_q[2*k+1]) : AW'(acc_q[2*k+1]);
    end
    max_new = mag_new[0];
    if (mag_new[1] > max_new) max_new = mag_new[1];
    if (mag_new[2] > max_new) max_new = mag_new[2];
  end

  // the root is final once the square root is done, so the first axis sees it too
  assign sq_trial = res_q + bit_q;
  assign div_num  = {1'b0, mag_q[cmd_i.idx[1:0]][29:0], 14'b0} + {15'b0, res_q[30:1]};
  assign div_t    = {r_q[31:0], nlow_q[15]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tension_q <= crpt_pkg::TENS_RESET;
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 4; i++) begin
          win_q[a][i] <= '0;
        end
      end
    end else begin
      if (tension_we_i) tension_q <= tension_i;
      if (cmd_i.op == crpt_pkg::DP_PUSH) begin
        for (int i = 0; i < 3; i++) begin
          win_q[0][i] <= win_q[0][i+1];
          win_q[1][i] <= win_q[1][i+1];
          win_q[2][i] <= win_q[2][i+1];
        end
        win_q[0][3] <= point_x_i;
        win_q[1][3] <= point_y_i;
        win_q[2][3] <= point_z_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    unique case (cmd_i.op)
      crpt_pkg::DP_LOAD: begin
        u_q <= (param_u_i > crpt_pkg::ONE_FX) ? crpt_pkg::ONE_FX : param_u_i;
        s_q <= (tension_q > crpt_pkg::ONE_FX) ? crpt_pkg::ONE_FX : tension_q;
      end
      crpt_pkg::DP_CAPT: begin
        unique case (cmd_i.idx[2:0])
          3'd0:    u2_q  <= p_rnd[32:16];
          3'd1:    u3_q  <= p_rnd[32:16];
          3'd2:    su_q  <= p_q[32:0];
          3'd3:    su2_q <= p_q[32:0];
          default: su3_q <= p_q[32:0];
        endcase
      end
      crpt_pkg::DP_WEIGHT: begin
        for (int i = 0; i < 4; i++) begin
          bw_q[i] <= rnd_w(bw_ex[i]);
          dw_q[i] <= rnd_w(dw_ex[i]);
        end
        for (int k = 0; k < 6; k++) begin
          acc_q[k] <= '0;
        end
      end
      crpt_pkg::DP_MAC: begin
        if (cmd_i.acc_en) acc_q[acc_sel] <= acc_q[acc_sel] + AW'(p_q);
      end
      crpt_pkg::DP_MAG: begin
        for (int k = 0; k < 3; k++) begin
          mag_q[k] <= mag_new[k];
          neg_q[k] <= acc_q[2*k+1][AW-1];
        end
        m_q   <= max_new;
        deg_q <= (max_new == '0);
        sum_q <= '0;
      end
      crpt_pkg::DP_NORM: begin
        // one bit a cycle until the largest magnitude sits in [2^29, 2^30)
        if (m_q[AW-1:30] != '0) begin
          m_q <= m_q >> 1;
          for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] >> 1;
        end else if (!m_q[29]) begin
          m_q <= m_q << 1;
          for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] << 1;
        end
      end
      crpt_pkg::DP_SQ: begin
        if (cmd_i.acc_en) sum_q <= sum_q + p_q;
      end
      crpt_pkg::DP_SQRT_INIT: begin
        rem_q <= sum_q;
        res_q <= '0;
        bit_q <= 64'h4000_0000_0000_0000;
      end
      crpt_pkg::DP_SQRT: begin
        if (rem_q >= sq_trial) begin
          rem_q <= rem_q - sq_trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      crpt_pkg::DP_DIV_INIT: begin
        n_q    <= res_q[30:0];
        r_q    <= {4'b0, div_num[44:16]};
        nlow_q <= div_num[15:0];
        q_q    <= '0;
      end
      crpt_pkg::DP_DIV: begin
        if (div_t >= {2'b0, n_q}) begin
          r_q <= div_t - {2'b0, n_q};
          q_q <= {q_q[14:0], 1'b1};
        end else begin
          r_q <= div_t;
          q_q <= {q_q[14:0], 1'b0};
        end
        nlow_q <= {nlow_q[14:0], 1'b0};
      end
      crpt_pkg::DP_DIV_DONE: begin
        dir_q[cmd_i.idx[1:0]] <= neg_q[cmd_i.idx[1:0]] ? -$signed(q_q) : $signed(q_q);
      end
      crpt_pkg::DP_OUT: begin
        pos_x_o          <= pos_sat(acc_q[0]);
        pos_y_o          <= pos_sat(acc_q[2]);
        pos_z_o          <= pos_sat(acc_q[4]);
        dir_x_o          <= deg_q ? '0 : dir_q[0];
        dir_y_o          <= deg_q ? '0 : dir_q[1];
        dir_z_o          <= deg_q ? '0 : dir_q[2];
        dir_degenerate_o <= deg_q;
      end
      default: begin
      end
    endcase
  end

  assign sts_o.zero     = deg_q;
  assign sts_o.in_range = (m_q[AW-1:29] == (AW-29)'(1));

  a_sqrt_after_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == crpt_pkg::DP_SQRT_INIT) |-> (m_q[AW-1:29] == (AW-29)'(1)))
    else $error("square root started before normalization finished");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == crpt_pkg::DP_DIV_INIT) |-> (res_q[63:31] == '0 && res_q[30:29] != 2'b00))
    else $error("vector length out of range");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == crpt_pkg::DP_DIV_DONE) |-> (q_q <= 16'd16384))
    else $error("tangent component above one");

endmodule

// File: rtl/catmull_rom_point_and_tangent.sv
// catmull_rom_point_and_tangent: cardinal spline segment evaluator, top level
// push item: no result. evaluate item, from accept to result valid: precompute, the
// basis weights, multiply-accumulate steps on one multiplier, a normalizer, squares,
// a root and three divides; a zero derivative skips from the normalizer to the result
// one item in work at a time; a result still stalled on the output holds the next result back
// reset clears the control point window to zero and sets tension to 0.5
module catmull_rom_point_and_tangent (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                tension_we_i,
  input  logic        [crpt_pkg::UQ_W-1:0]    tension_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                operation_i,
  input  logic signed [crpt_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [crpt_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [crpt_pkg::COORD_W-1:0] point_z_i,
  input  logic        [crpt_pkg::UQ_W-1:0]    param_u_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [crpt_pkg::COORD_W-1:0] pos_x_o,
  output logic signed [crpt_pkg::COORD_W-1:0] pos_y_o,
  output logic signed [crpt_pkg::COORD_W-1:0] pos_z_o,
  output logic signed [crpt_pkg::DIR_W-1:0]   dir_x_o,
  output logic signed [crpt_pkg::DIR_W-1:0]   dir_y_o,
  output logic signed [crpt_pkg::DIR_W-1:0]   dir_z_o,
  output logic                                dir_degenerate_o
);

  crpt_pkg::dp_cmd_t cmd;
  crpt_pkg::dp_sts_t sts;

  crpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  crpt_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .tension_we_i     (tension_we_i),
    .tension_i        (tension_i),
    .point_x_i        (point_x_i),
    .point_y_i        (point_y_i),
    .point_z_i        (point_z_i),
    .param_u_i        (param_u_i),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o),
    .pos_z_o          (pos_z_o),
    .dir_x_o          (dir_x_o),
    .dir_y_o          (dir_y_o),
    .dir_z_o          (dir_z_o),
    .dir_degenerate_o (dir_degenerate_o)
  );

endmodule
